// File: hdl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// shared constants and types for the environmental sensor compensation block
// ----------------------------------------------------------------------------
package esc_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_TEMP      = 3'd0,
    REG_PRESS_LOW = 3'd1,
    REG_PRESS_MID = 3'd2,
    REG_PRESS_P9  = 3'd3,
    REG_HUMID     = 3'd4
  } esc_reg_t;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 64;

  // pipeline shape
  localparam int unsigned DivStages = 64;  // one quotient bit per stage
  localparam int unsigned SideDelay = 67;  // temperature / humidity hold line
  localparam int unsigned ValidLen  = 81;  // valid chain up to the output stage

  // temperature and humidity results travelling alongside pressure
  typedef struct packed {
    logic signed [31:0] temp;
    logic [16:0]        hum;
  } esc_side_t;

endpackage

// File: hdl/environmental_sensor_compensation_top.sv
// ----------------------------------------------------------------------------
// environmental_sensor_compensation_top
// integer compensation of raw pressure, temperature and humidity samples
// ----------------------------------------------------------------------------
// Usage:
//   A sample triple is taken on raw_pressure, raw_temperature and
//   raw_humidity at every clock edge with start high and busy low. busy is
//   always low: the datapath is fully pipelined and takes a new transaction
//   every cycle.
//   The result appears on temperature_centi, pressure_q24_8, humidity_q22_10
//   and pressure_invalid for one cycle, marked by done, from the output
//   register. The pipeline depth is set by the 64-stage restoring divider of the
//   pressure path, one quotient bit per stage, plus the multiply stages
//   around it. Throughput is one transaction per cycle.
//   Calibration words are written through wr_en / wr_index / wr_data while
//   no transaction is in flight; unknown indexes are ignored.
//   Synchronous reset clears all calibration words and the valid chain;
//   nothing is lost to a stall since the receiver always takes done.
// ----------------------------------------------------------------------------
module environmental_sensor_compensation_top
  import esc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [19:0]          raw_pressure,
  input  logic [19:0]          raw_temperature,
  input  logic [15:0]          raw_humidity,
  input  logic                 wr_en,
  input  logic [CfgIndexW-1:0] wr_index,
  input  logic [CfgDataW-1:0]  wr_data,
  output logic                 done,
  output logic signed [31:0]   temperature_centi,
  output logic [31:0]          pressure_q24_8,
  output logic [16:0]          humidity_q22_10,
  output logic                 pressure_invalid
);

  // calibration registers
  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_low;
  logic [63:0] press_coeffs_mid;
  logic [15:0] press_coeff_nine;
  logic [63:0] humid_coeffs;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs      <= '0;
      press_coeffs_low <= '0;
      press_coeffs_mid <= '0;
      press_coeff_nine <= '0;
      humid_coeffs     <= '0;
    end else if (wr_en) begin
      case (esc_reg_t'(wr_index))
        REG_TEMP:      temp_coeffs      <= wr_data[47:0];
        REG_PRESS_LOW: press_coeffs_low <= wr_data;
        REG_PRESS_MID: press_coeffs_mid <= wr_data;
        REG_PRESS_P9:  press_coeff_nine <= wr_data[15:0];
        REG_HUMID:     humid_coeffs     <= wr_data;
        default: ;
      endcase
    end
  end

  // coefficient fields
  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  logic signed [16:0] p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
  logic signed [8:0]  h1, h3;
  logic signed [15:0] h2;
  logic signed [11:0] h4, h5;
  logic signed [7:0]  h6;

  assign t1 = temp_coeffs[15:0];
  assign t2 = temp_coeffs[31:16];
  assign t3 = temp_coeffs[47:32];
  assign p1 = {1'b0, press_coeffs_low[15:0]};
  assign p2 = press_coeffs_low[31:16];
  assign p3 = press_coeffs_low[47:32];
  assign p4 = press_coeffs_low[63:48];
  assign p5 = press_coeffs_mid[15:0];
  assign p6 = press_coeffs_mid[31:16];
  assign p7 = press_coeffs_mid[47:32];
  assign p8 = press_coeffs_mid[63:48];
  assign p9 = press_coeff_nine;
  assign h1 = {1'b0, humid_coeffs[7:0]};
  assign h2 = humid_coeffs[23:8];
  assign h3 = {1'b0, humid_coeffs[31:24]};
  assign h4 = humid_coeffs[43:32];
  assign h5 = humid_coeffs[55:44];
  assign h6 = humid_coeffs[63:56];

  assign busy = 1'b0;

  // valid chain
  logic [ValidLen:1] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[ValidLen-1:1], start & ~busy};
    end
  end

  // stage 1: capture transaction
  logic [19:0] s1_ap, s1_at;
  logic [15:0] s1_ah;
  always_ff @(posedge clk) begin
    s1_ap <= raw_pressure;
    s1_at <= raw_temperature;
    s1_ah <= raw_humidity;
  end

  // stage 2: temperature differences
  logic signed [31:0] s2_ta, s2_d;
  logic [19:0]        s2_ap;
  logic [15:0]        s2_ah;
  always_ff @(posedge clk) begin
    s2_ta <= $signed({15'd0, s1_at[19:3]}) - $signed({15'd0, t1, 1'b0});
    s2_d  <= $signed({16'd0, s1_at[19:4]}) - $signed({16'd0, t1});
    s2_ap <= s1_ap;
    s2_ah <= s1_ah;
  end

  // stage 3: first temperature products
  logic signed [31:0] s3_ta2, s3_dd;
  logic signed [31:0] s3_a, s3_dsq;
  logic [19:0]        s3_ap;
  logic [15:0]        s3_ah;
  assign s3_ta2 = s2_ta * t2;
  assign s3_dd  = s2_d * s2_d;
  always_ff @(posedge clk) begin
    s3_a   <= s3_ta2 >>> 11;
    s3_dsq <= s3_dd;
    s3_ap  <= s2_ap;
    s3_ah  <= s2_ah;
  end

  // stage 4: quadratic temperature term
  logic signed [31:0] s4_a, s4_b1;
  logic [19:0]        s4_ap;
  logic [15:0]        s4_ah;
  always_ff @(posedge clk) begin
    s4_a  <= s3_a;
    s4_b1 <= (s3_dsq >>> 12) * t3;
    s4_ap <= s3_ap;
    s4_ah <= s3_ah;
  end

  // stage 5: fine temperature
  logic signed [31:0] s5_tf;
  logic [19:0]        s5_ap;
  logic [15:0]        s5_ah;
  always_ff @(posedge clk) begin
    s5_tf <= s4_a + (s4_b1 >>> 14);
    s5_ap <= s4_ap;
    s5_ah <= s4_ah;
  end

  // stage 6: temperature result and offsets for pressure / humidity
  logic signed [31:0] s6_t5;
  logic signed [31:0] s6_temp, s6_x;
  logic signed [33:0] s6_v1;
  logic [19:0]        s6_ap;
  logic [15:0]        s6_ah;
  assign s6_t5 = s5_tf * 32'sd5 + 32'sd128;
  always_ff @(posedge clk) begin
    s6_temp <= s6_t5 >>> 8;
    s6_v1   <= $signed({{2{s5_tf[31]}}, s5_tf}) - 34'sd128000;
    s6_x    <= s5_tf - 32'sd76800;
    s6_ap   <= s5_ap;
    s6_ah   <= s5_ah;
  end

  // ---------------- pressure, ahead of the divider ----------------

  // stage 7: square and linear products
  logic signed [63:0] s7_vv, s7_v5, s7_v2m;
  logic [19:0]        s7_ap;
  always_ff @(posedge clk) begin
    s7_vv  <= s6_v1 * s6_v1;
    s7_v5  <= s6_v1 * p5;
    s7_v2m <= s6_v1 * p2;
    s7_ap  <= s6_ap;
  end

  // stage 8: square scaled by coefficients
  logic signed [63:0] s8_v2a, s8_v3, s8_v5, s8_v2m;
  logic [19:0]        s8_ap;
  always_ff @(posedge clk) begin
    s8_v2a <= s7_vv * p6;
    s8_v3  <= s7_vv * p3;
    s8_v5  <= s7_v5;
    s8_v2m <= s7_v2m;
    s8_ap  <= s7_ap;
  end

  // stage 9: sums of the var terms
  logic signed [63:0] s9_p4x;
  logic signed [63:0] s9_v2, s9_v1b;
  logic [19:0]        s9_ap;
  assign s9_p4x = p4;
  always_ff @(posedge clk) begin
    s9_v2  <= s8_v2a + (s8_v5 <<< 17) + (s9_p4x <<< 35);
    s9_v1b <= (s8_v3 >>> 8) + (s8_v2m <<< 12);
    s9_ap  <= s8_ap;
  end

  // stage 10: divisor product and numerator base
  logic signed [63:0] s10_pn;
  logic signed [63:0] s10_prod, s10_nn;
  assign s10_pn = $signed(64'd1048576 - {44'd0, s9_ap});
  always_ff @(posedge clk) begin
    s10_prod <= (s9_v1b + 64'sd140737488355328) * p1;
    s10_nn   <= (s10_pn <<< 31) - s9_v2;
  end

  // stage 11: divisor and dividend
  logic signed [63:0] s11_dsr, s11_dvd;
  always_ff @(posedge clk) begin
    s11_dsr <= s10_prod >>> 33;
    s11_dvd <= s10_nn * 64'sd3125;
  end

  // stage 12 (divider entry): magnitudes and signs
  logic [63:0] drem [0:DivStages];
  logic [63:0] ddvd [0:DivStages];
  logic [63:0] ddsr [0:DivStages];
  logic        dneg [0:DivStages];
  logic        dbad [0:DivStages];

  always_ff @(posedge clk) begin
    drem[0] <= '0;
    ddvd[0] <= s11_dvd[63] ? (64'd0 - s11_dvd) : s11_dvd;
    ddsr[0] <= s11_dsr[63] ? (64'd0 - s11_dsr) : s11_dsr;
    dneg[0] <= s11_dvd[63] ^ s11_dsr[63];
    dbad[0] <= (s11_dsr == 64'sd0);
  end

  // restoring divider, one quotient bit per stage
  for (genvar i = 1; i <= DivStages; i++) begin : g_div
    logic [64:0] trial;
    logic [64:0] diff;
    logic        fits;
    assign trial = {drem[i-1], ddvd[i-1][63]};
    assign diff  = trial - {1'b0, ddsr[i-1]};
    assign fits  = ~diff[64];
    always_ff @(posedge clk) begin
      drem[i] <= fits ? diff[63:0] : trial[63:0];
      ddvd[i] <= {ddvd[i-1][62:0], fits};
      ddsr[i] <= ddsr[i-1];
      dneg[i] <= dneg[i-1];
      dbad[i] <= dbad[i-1];
    end
  end

  // ---------------- pressure, after the divider ----------------

  // e1: signed quotient
  logic signed [63:0] e1_p;
  logic               e1_bad;
  always_ff @(posedge clk) begin
    e1_p   <= dneg[DivStages] ? $signed(64'd0 - ddvd[DivStages])
                              : $signed(ddvd[DivStages]);
    e1_bad <= dbad[DivStages];
  end

  // e2: partial products of the square and the p8 term
  logic [63:0]        e2_q;
  logic [63:0]        e2_ll;
  logic [31:0]        e2_lh;
  logic signed [63:0] e2_pp8, e2_p;
  logic               e2_bad;
  assign e2_q = e1_p >>> 13;
  always_ff @(posedge clk) begin
    e2_ll  <= e2_q[31:0] * e2_q[31:0];
    e2_lh  <= e2_q[31:0] * e2_q[63:32];
    e2_pp8 <= e1_p * p8;
    e2_p   <= e1_p;
    e2_bad <= e1_bad;
  end

  // e3: square modulo 2^64
  logic [63:0]        e3_sq;
  logic signed [63:0] e3_pp8, e3_p;
  logic               e3_bad;
  always_ff @(posedge clk) begin
    e3_sq  <= e2_ll + {e2_lh[30:0], 33'd0};
    e3_pp8 <= e2_pp8;
    e3_p   <= e2_p;
    e3_bad <= e2_bad;
  end

  // e4: p9 term
  logic signed [63:0] e4_s9, e4_pp8, e4_p;
  logic               e4_bad;
  always_ff @(posedge clk) begin
    e4_s9  <= $signed(e3_sq) * p9;
    e4_pp8 <= e3_pp8;
    e4_p   <= e3_p;
    e4_bad <= e3_bad;
  end

  // e5: correction sum
  logic signed [63:0] e5_r;
  logic               e5_bad;
  always_ff @(posedge clk) begin
    e5_r   <= e4_p + (e4_s9 >>> 25) + (e4_pp8 >>> 19);
    e5_bad <= e4_bad;
  end

  // ---------------- humidity ----------------

  // h7: products with the temperature offset
  logic signed [31:0] h7_h5x, h7_m6, h7_m3, h7_temp;
  logic [15:0]        h7_ah;
  always_ff @(posedge clk) begin
    h7_h5x  <= s6_x * h5;
    h7_m6   <= s6_x * h6;
    h7_m3   <= s6_x * h3;
    h7_temp <= s6_temp;
    h7_ah   <= s6_ah;
  end

  // h8: offset term and temperature factor
  logic signed [31:0] h8_hsum, h8_f;
  logic signed [31:0] h8_ha, h8_hb, h8_temp;
  assign h8_hsum = $signed({2'd0, h7_ah, 14'd0}) - ($signed(32'(h4)) <<< 20)
                   - h7_h5x + 32'sd16384;
  assign h8_f    = (h7_m3 >>> 11) + 32'sd32768;
  always_ff @(posedge clk) begin
    h8_ha   <= h8_hsum >>> 15;
    h8_hb   <= (h7_m6 >>> 10) * h8_f;
    h8_temp <= h7_temp;
  end

  // h9: scale by h2
  logic signed [31:0] h9_hbm, h9_ha, h9_temp;
  always_ff @(posedge clk) begin
    h9_hbm  <= ((h8_hb >>> 10) + 32'sd2097152) * h2;
    h9_ha   <= h8_ha;
    h9_temp <= h8_temp;
  end

  // h10: round
  logic signed [31:0] h10_sum;
  logic signed [31:0] h10_hb, h10_ha, h10_temp;
  assign h10_sum = h9_hbm + 32'sd8192;
  always_ff @(posedge clk) begin
    h10_hb   <= h10_sum >>> 14;
    h10_ha   <= h9_ha;
    h10_temp <= h9_temp;
  end

  // h11: raw humidity product
  logic signed [31:0] h11_xx, h11_temp;
  always_ff @(posedge clk) begin
    h11_xx   <= h10_ha * h10_hb;
    h11_temp <= h10_temp;
  end

  // h12: square of the scaled product
  logic signed [31:0] h12_s;
  logic signed [31:0] h12_ss, h12_xx, h12_temp;
  assign h12_s = h11_xx >>> 15;
  always_ff @(posedge clk) begin
    h12_ss   <= h12_s * h12_s;
    h12_xx   <= h11_xx;
    h12_temp <= h11_temp;
  end

  // h13: h1 correction
  logic signed [31:0] h13_t, h13_xx, h13_temp;
  always_ff @(posedge clk) begin
    h13_t    <= (h12_ss >>> 7) * h1;
    h13_xx   <= h12_xx;
    h13_temp <= h12_temp;
  end

  // h14: clamp to 0..100 %RH
  logic signed [31:0] h14_x2;
  logic [31:0]        h14_cl;
  esc_side_t          h14_side;
  assign h14_x2 = h13_xx - (h13_t >>> 4);
  always_comb begin
    if (h14_x2[31]) begin
      h14_cl = 32'd0;
    end else if (h14_x2 > 32'sd419430400) begin
      h14_cl = 32'd419430400;
    end else begin
      h14_cl = h14_x2;
    end
  end
  always_ff @(posedge clk) begin
    h14_side.temp <= h13_temp;
    h14_side.hum  <= h14_cl[28:12];
  end

  // hold line meeting the pressure path
  esc_side_t side_dly [0:SideDelay-1];
  always_ff @(posedge clk) begin
    side_dly[0] <= h14_side;
    for (int k = 1; k < SideDelay; k++) begin
      side_dly[k] <= side_dly[k-1];
    end
  end

  // output stage
  logic signed [63:0] out_pr;
  assign out_pr = (e5_r >>> 8) + ($signed(64'(p7)) <<< 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[ValidLen];
    end
    temperature_centi <= side_dly[SideDelay-1].temp;
    humidity_q22_10   <= side_dly[SideDelay-1].hum;
    pressure_q24_8    <= e5_bad ? 32'd0 : out_pr[31:0];
    pressure_invalid  <= e5_bad;
  end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the environmental sensor compensation block: a
// table of directed sample triples, then random triple bursts over several
// calibrations, results checked by table entries or in-bench compensation
// ----------------------------------------------------------------------------
module tb_top
  import esc_pkg::*;
();

  localparam int unsigned Latency   = 82;
  localparam int unsigned SettleCyc = Latency + 8;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned RandItems = 1950;
  localparam logic [CfgIndexW-1:0] RegUnused = 3'd7;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] press;
    logic [16:0] hum;
    logic        invalid;
  } reading_t;

  typedef struct {
    logic [19:0] p;
    logic [19:0] t;
    logic [15:0] h;
    int          cal;      // 0: calibration after reset, 1: typical part
    bit          typed;
    reading_t    want;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [19:0] raw_pressure = '0;
  logic [19:0] raw_temperature = '0;
  logic [15:0] raw_humidity = '0;
  logic wr_en = 1'b0;
  logic [CfgIndexW-1:0] wr_index = '0;
  logic [CfgDataW-1:0] wr_data = '0;
  logic done;
  logic signed [31:0] temperature_centi;
  logic [31:0] pressure_q24_8;
  logic [16:0] humidity_q22_10;
  logic pressure_invalid;

  // calibration copy held by the bench
  logic [47:0] cal_temp;
  logic [63:0] cal_plow;
  logic [63:0] cal_pmid;
  logic [15:0] cal_p9;
  logic [63:0] cal_hum;

  reading_t pending_q[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  environmental_sensor_compensation_top dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] asr32(logic [31:0] x, int n);
    logic signed [31:0] s;
    s = x;
    return s >>> n;
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int n);
    logic signed [63:0] s;
    s = x;
    return s >>> n;
  endfunction

  // integer compensation of one sample triple with the current calibration
  function automatic reading_t compensate(logic [19:0] ap, logic [19:0] at, logic [15:0] ah);
    reading_t r;
    logic [31:0] t1, t2, t3, at32, m, a, b, d, tf;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, w, p, n, an, ad, q;
    logic [31:0] h1, h2, h3, h4, h5, h6, x, ha, hb, u, s, ah32;
    r = '0;
    at32 = {12'd0, at};
    t1 = {16'd0, cal_temp[15:0]};
    t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
    t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
    // temperature, 32-bit wrap
    m = ((at32 >> 3) - (t1 << 1)) * t2;
    a = asr32(m, 11);
    d = (at32 >> 4) - t1;
    m = asr32(d * d, 12) * t3;
    b = asr32(m, 14);
    tf = a + b;
    r.temp = asr32(tf * 32'd5 + 32'd128, 8);
    // pressure, 64-bit wrap
    p1 = {48'd0, cal_plow[15:0]};
    p2 = {{48{cal_plow[31]}}, cal_plow[31:16]};
    p3 = {{48{cal_plow[47]}}, cal_plow[47:32]};
    p4 = {{48{cal_plow[63]}}, cal_plow[63:48]};
    p5 = {{48{cal_pmid[15]}}, cal_pmid[15:0]};
    p6 = {{48{cal_pmid[31]}}, cal_pmid[31:16]};
    p7 = {{48{cal_pmid[47]}}, cal_pmid[47:32]};
    p8 = {{48{cal_pmid[63]}}, cal_pmid[63:48]};
    p9 = {{48{cal_p9[15]}}, cal_p9};
    v1 = {{32{tf[31]}}, tf} - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
    if (v1 == 64'd0) begin
      r.invalid = 1'b1;
    end else begin
      p = 64'd1048576 - {44'd0, ap};
      n = ((p << 31) - v2) * 64'd3125;
      // truncating signed division through magnitudes
      an = n[63] ? -n : n;
      ad = v1[63] ? -v1 : v1;
      q = an / ad;
      p = (n[63] != v1[63]) ? -q : q;
      q = asr64(p, 13);
      v1 = asr64(p9 * q * q, 25);
      v2 = asr64(p8 * p, 19);
      w = asr64(p + v1 + v2, 8) + (p7 << 4);
      r.press = w[31:0];
    end
    // humidity, 32-bit wrap with clamp
    ah32 = {16'd0, ah};
    h1 = {24'd0, cal_hum[7:0]};
    h2 = {{16{cal_hum[23]}}, cal_hum[23:8]};
    h3 = {24'd0, cal_hum[31:24]};
    h4 = {{20{cal_hum[43]}}, cal_hum[43:32]};
    h5 = {{20{cal_hum[55]}}, cal_hum[55:44]};
    h6 = {{24{cal_hum[63]}}, cal_hum[63:56]};
    x = tf - 32'd76800;
    ha = asr32((ah32 << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
    u = asr32(x * h6, 10);
    hb = u * (asr32(x * h3, 11) + 32'd32768);
    hb = asr32(hb, 10) + 32'd2097152;
    hb = asr32(hb * h2 + 32'd8192, 14);
    x = ha * hb;
    s = asr32(x, 15);
    x = x - asr32(asr32(s * s, 7) * h1, 4);
    if (x[31]) begin
      x = 32'd0;
    end else if (x > 32'd419430400) begin
      x = 32'd419430400;
    end
    r.hum = x[28:12];
    return r;
  endfunction

  // result checker and stall watchdog
  always @(posedge clk) begin
    reading_t got, want;
    if (!rst) begin
      if ((start && !busy) || done || wr_en) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
      if (done) begin
        got = '{temperature_centi, pressure_q24_8, humidity_q22_10, pressure_invalid};
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = pending_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: temp %h/%h press %h/%h hum %h/%h inv %b/%b (exp/act)",
                       want.temp, got.temp, want.press, got.press,
                       want.hum, got.hum, want.invalid, got.invalid);
            end
          end
        end
      end
    end
  end

  // one register write; the enable stays up for back-to-back writes
  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [63:0] val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    case (idx)
      REG_TEMP:      cal_temp = val[47:0];
      REG_PRESS_LOW: cal_plow = val;
      REG_PRESS_MID: cal_pmid = val;
      REG_PRESS_P9:  cal_p9 = val[15:0];
      REG_HUMID:     cal_hum = val;
      default: ;
    endcase
  endtask

  task automatic load_calibration(logic [47:0] tc, logic [63:0] pl, logic [63:0] pm,
                                  logic [15:0] p9, logic [63:0] hc);
    write_reg(REG_TEMP, {16'($urandom), tc});
    write_reg(REG_PRESS_LOW, pl);
    write_reg(REG_PRESS_MID, pm);
    write_reg(REG_PRESS_P9, {32'($urandom), 16'($urandom), p9});
    write_reg(REG_HUMID, hc);
    write_reg(RegUnused, {$urandom, $urandom});
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  // present one transaction and hold it until accepted
  task automatic send_sample(logic [19:0] p, logic [19:0] t, logic [15:0] h,
                             bit typed, reading_t want);
    @(negedge clk);
    start <= 1'b1;
    raw_pressure <= p;
    raw_temperature <= t;
    raw_humidity <= h;
    do @(posedge clk); while (busy);
    pending_q.push_back(typed ? want : compensate(p, t, h));
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  function automatic logic [19:0] pick20();
    case ($urandom_range(0, 9))
      0: return 20'd0;
      1: return 20'hFFFFF;
      default: return 20'($urandom);
    endcase
  endfunction

  // typical calibration of a production part
  task automatic load_typical();
    load_calibration({16'hFC18, 16'd26435, 16'd27504},
                     {16'd2855, 16'd3024, 16'hD743, 16'd36477},
                     {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000,
                     {8'd30, 12'd0, 12'd324, 8'd0, 16'd362, 8'd75});
  endtask

  initial begin
    sample_row_t rows[$];
    reading_t none_expected;
    int cur_cal;
    int sent;
    int burst;
    int phase;
    none_expected = '{32'd0, 32'd0, 17'd0, 1'b1};
    cal_temp = '0;
    cal_plow = '0;
    cal_pmid = '0;
    cal_p9 = '0;
    cal_hum = '0;
    // directed table: zero calibration gives invalid pressure and zeros elsewhere
    rows = '{
      '{20'd0, 20'd0, 16'd0, 0, 1, none_expected},
      '{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0, 1, none_expected},
      '{20'hAAAAA, 20'h55555, 16'hAAAA, 0, 1, none_expected},
      '{20'h55555, 20'hAAAAA, 16'h5555, 0, 1, none_expected},
      '{20'd415148, 20'd519888, 16'd30000, 1, 0, none_expected},
      '{20'd0, 20'd0, 16'd0, 1, 0, none_expected},
      '{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1, 0, none_expected},
      '{20'd0, 20'hFFFFF, 16'd0, 1, 0, none_expected},
      '{20'hFFFFF, 20'd0, 16'hFFFF, 1, 0, none_expected},
      '{20'd300000, 20'd500000, 16'd65535, 1, 0, none_expected},
      '{20'd600000, 20'd540000, 16'd0, 1, 0, none_expected},
      '{20'd1048575, 20'd400000, 16'd20000, 1, 0, none_expected}
    };
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    cur_cal = 0;
    foreach (rows[i]) begin
      if (rows[i].cal != cur_cal) begin
        drain();
        load_typical();
        cur_cal = rows[i].cal;
      end
      send_sample(rows[i].p, rows[i].t, rows[i].h, rows[i].typed, rows[i].want);
    end
    // random phases over several calibrations, each starting from an idle block
    sent = 0;
    phase = 0;
    while (sent < RandItems) begin
      drain();
      case (phase % 5)
        0: load_typical();
        1: load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
                            {$urandom, $urandom}, 16'($urandom), {$urandom, $urandom});
        2: load_calibration('1, '1, '1, '1, '1);
        3: load_calibration(48'h8000_8000_FFFF, 64'h8000_8000_8000_FFFF,
                            64'h8000_8000_8000_8000, 16'h8000, 64'h8080_0800_8080_00FF);
        default: load_calibration(48'({$urandom, $urandom}),
                                  {16'($urandom), $urandom, 16'($urandom_range(0, 3))},
                                  {$urandom, $urandom}, 16'($urandom), {$urandom, $urandom});
      endcase
      phase++;
      repeat (RandItems / 10) begin
        burst = $urandom_range(1, 40);
        repeat (burst) begin
          send_sample(pick20(), pick20(), 16'($urandom), 1'b0, none_expected);
          sent++;
        end
        if ($urandom_range(0, 3) != 0) begin
          @(negedge clk);
          start <= 1'b0;
          repeat ($urandom_range(0, 6)) @(negedge clk);
        end
        if (sent >= (phase * RandItems) / 8) break;
      end
    end
    drain();
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/esc_pkg.sv
hdl/environmental_sensor_compensation_top.sv
dv/tb_top.sv
